// ===== src/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants and controller/datapath interface types for the sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        SRC_SAMPLE = 2'd0,
        SRC_RDATA  = 2'd1,
        SRC_HOLD   = 2'd2
    } t_wr_src;

    typedef struct packed {
        logic [AW-1:0] rd_addr;
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        t_wr_src       wr_src;
        logic          hold_ld;
        logic          out_ld;
        logic          out_end;
        logic          out_drop;
    } t_cmd;

    typedef struct packed {
        logic gt;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== src/bsa_dp.sv =====
// ----------------------------------------------------------------------------
// bsa_dp
// Datapath: element store, carried bubble element, comparator, output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bsa_pkg::t_cmd              i_cmd,
    output bsa_pkg::t_status                o_status,
    input  wire logic [bsa_pkg::DATA_W-1:0] i_sample,
    input  wire logic                       i_stall,
    output logic                            o_valid,
    output logic [bsa_pkg::DATA_W-1:0]      o_sorted_value,
    output logic                            o_end_of_run,
    output logic                            o_dropped
);
    import bsa_pkg::*;

    logic        [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;
    logic signed [DATA_W-1:0] r_hold;
    logic        [DATA_W-1:0] wr_data;
    logic                     r_out_valid;
    logic        [DATA_W-1:0] r_out_value;
    logic                     r_out_end;
    logic                     r_out_drop;

    always_comb begin
        unique case (i_cmd.wr_src)
            SRC_SAMPLE: wr_data = i_sample;
            SRC_RDATA:  wr_data = r_rdata;
            SRC_HOLD:   wr_data = r_hold;
            default:    wr_data = r_hold;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_ld) begin
            r_hold <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_value <= r_rdata;
            r_out_end   <= i_cmd.out_end;
            r_out_drop  <= i_cmd.out_drop;
        end
    end

    assign o_status.gt       = (r_hold > r_rdata);
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_end_of_run   = r_out_end;
    assign o_dropped      = r_out_drop;

endmodule

`default_nettype wire

// ===== src/bsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsa_ctrl
// Controller: load counting, bubble pass sequencing with early exit, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_final_item,
    output logic                  o_stall,
    input  wire bsa_pkg::t_status i_status,
    output bsa_pkg::t_cmd         o_cmd
);
    import bsa_pkg::*;

    typedef enum logic [6:0] {
        ST_LOAD = 7'b0000001,
        ST_PASS = 7'b0000010,
        ST_HOLD = 7'b0000100,
        ST_CMP  = 7'b0001000,
        ST_TAIL = 7'b0010000,
        ST_ERD  = 7'b0100000,
        ST_EOUT = 7'b1000000
    } t_state;

    t_state        r_state,    n_state;
    logic [CW-1:0] r_count,    n_count;
    logic          r_overflow, n_overflow;
    logic [AW-1:0] r_idx,      n_idx;
    logic [AW-1:0] r_limit,    n_limit;
    logic          r_swapped,  n_swapped;

    logic          accept;
    logic          has_room;
    logic [CW-1:0] cnt_inc;
    logic          last_out;
    logic          more_cmp;

    assign accept   = i_valid && (r_state == ST_LOAD);
    assign has_room = (r_count < CW'(DEPTH));
    assign cnt_inc  = has_room ? (r_count + 1'b1) : r_count;
    assign last_out = ((CW'(r_idx) + 1'b1) == r_count);
    assign more_cmp = ((AW'(r_idx) + 1'b1) < r_limit) && (r_idx != AW'(DEPTH - 1));
    assign o_stall  = (r_state != ST_LOAD);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_overflow = r_overflow;
        n_idx      = r_idx;
        n_limit    = r_limit;
        n_swapped  = r_swapped;

        o_cmd          = '0;
        o_cmd.wr_src   = SRC_SAMPLE;
        o_cmd.rd_addr  = r_idx;
        o_cmd.out_drop = r_overflow;
        o_cmd.out_end  = last_out;

        unique case (r_state)
            ST_LOAD: begin
                o_cmd.wr_addr = r_count[AW-1:0];
                o_cmd.wr_src  = SRC_SAMPLE;
                if (accept) begin
                    o_cmd.wr_en = has_room;
                    n_count     = cnt_inc;
                    if (!has_room) begin
                        n_overflow = 1'b1;
                    end
                    if (i_final_item) begin
                        n_idx   = '0;
                        n_limit = AW'(cnt_inc - 1'b1);
                        if (cnt_inc < CW'(2)) begin
                            n_state = ST_ERD;
                        end else begin
                            n_state = ST_PASS;
                        end
                    end
                end
            end
            ST_PASS: begin
                o_cmd.rd_addr = '0;
                n_swapped     = 1'b0;
                n_state       = ST_HOLD;
            end
            ST_HOLD: begin
                o_cmd.rd_addr = AW'(1);
                o_cmd.hold_ld = 1'b1;
                n_idx         = '0;
                n_state       = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_idx;
                o_cmd.rd_addr = r_idx + AW'(2);
                if (i_status.gt) begin
                    o_cmd.wr_src = SRC_RDATA;
                    n_swapped    = 1'b1;
                end else begin
                    o_cmd.wr_src  = SRC_HOLD;
                    o_cmd.hold_ld = 1'b1;
                end
                if (more_cmp) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_limit;
                o_cmd.wr_src  = SRC_HOLD;
                n_limit       = r_limit - 1'b1;
                n_idx         = '0;
                if (r_swapped && (r_limit != AW'(1))) begin
                    n_state = ST_PASS;
                end else begin
                    n_state = ST_ERD;
                end
            end
            ST_ERD: begin
                o_cmd.rd_addr = r_idx;
                n_state       = ST_EOUT;
            end
            ST_EOUT: begin
                o_cmd.rd_addr = r_idx;
                if (i_status.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    if (last_out) begin
                        n_count    = '0;
                        n_overflow = 1'b0;
                        n_state    = ST_LOAD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_ERD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_idx      <= '0;
            r_limit    <= '0;
            r_swapped  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_idx      <= n_idx;
            r_limit    <= n_limit;
            r_swapped  <= n_swapped;
        end
    end

endmodule

`default_nettype wire

// ===== src/bubble_sort_ascending.sv =====
// A run of n elements loads at one element per cycle; each bubble pass then
//   runs PASS, HOLD, CMP compares, TAIL; up to n-1 passes, fewer on early exit.
// Results leave one at a time, a store read then an output register load,
//   set by the single-port-read element store; input stalls until the last loads.
// Reset (synchronous, active low) clears the controller and output valid;
//   the element store is not cleared.
// ----------------------------------------------------------------------------
// bubble_sort_ascending
// Collects signed elements up to a final marker, bubble sorts them in place
// with early exit, and streams them out ascending.
// ----------------------------------------------------------------------------
`default_nettype none

module bubble_sort_ascending (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [bsa_pkg::DATA_W-1:0] i_sample,
    input  wire logic                       i_final_item,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [bsa_pkg::DATA_W-1:0]      o_sorted_value,
    output logic                            o_end_of_run,
    output logic                            o_dropped
);
    import bsa_pkg::*;

    t_cmd    cmd;
    t_status status;

    bsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_final_item (i_final_item),
        .o_stall      (o_stall),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    bsa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sample       (i_sample),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_end_of_run   (o_end_of_run),
        .o_dropped      (o_dropped)
    );

endmodule

`default_nettype wire

// ===== tb/tb_bubble_sort_ascending.sv =====
// ----------------------------------------------------------------------------
// tb_bubble_sort_ascending
// Streams sets of signed samples into the sorter. Each set closes on a
// final-item marker. Sets include single elements, duplicates, extreme values,
// presorted and reversed orders, and sets larger than the store, whose excess
// requests are dropped. An in-bench model sorts each collected set the way the
// block does and queues the expected output. A monitor checks every sorted
// value, end marker and drop flag in order. Requests arrive in bursts with
// random gaps, and the output side stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_bubble_sort_ascending;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W           = bsa_pkg::DATA_W;
    localparam int DEPTH       = bsa_pkg::DEPTH;
    localparam int RAND_ITEMS  = 125;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 64;

    localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};

    typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EXTREME} t_value_mix;
    typedef enum int {ORD_RANDOM, ORD_RISING, ORD_FALLING} t_order;
    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_COMB} t_stall_mode;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic                last;
    } t_sample_req;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic                last;
        logic                drop;
    } t_sorted_word;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                o_stall;
    logic signed [W-1:0] i_sample     = '0;
    logic                i_final_item = 1'b0;
    logic                o_valid;
    logic                i_stall      = 1'b0;
    logic [W-1:0]        o_sorted_value;
    logic                o_end_of_run;
    logic                o_dropped;

    t_sample_req         samples_pending[$];
    t_sorted_word        sorted_due[$];
    logic signed [W-1:0] set_vals[$];
    logic                set_dropped   = 1'b0;

    int                  mismatches    = 0;
    int                  sets_sorted   = 0;
    int                  overflow_sets = 0;
    int                  values_seen   = 0;
    int                  idle_cycles   = 0;
    int                  burst_left    = 1;
    int                  gap_left      = 0;
    logic                flush         = 1'b0;
    t_stall_mode         stall_mode    = STALL_NONE;
    int                  stall_span    = 0;
    int                  stall_tick    = 0;

    bubble_sort_ascending u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_final_item   (i_final_item),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_end_of_run   (o_end_of_run),
        .o_dropped      (o_dropped)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [W-1:0] pick_value(t_value_mix mix);
        logic signed [W-1:0] v;
        case (mix)
            VAL_NARROW: begin
                v = $signed($urandom_range(0, 6)) - 3;
            end
            VAL_EXTREME: begin
                case ($urandom_range(0, 5))
                    0: v = S_MIN;
                    1: v = S_MAX;
                    2: v = '0;
                    3: v = -1;
                    4: v = S_MIN + 1;
                    default: v = S_MAX - 1;
                endcase
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    function automatic void push_sample(logic signed [W-1:0] v, logic fin);
        t_sample_req r;
        r.value = v;
        r.last  = fin;
        samples_pending.push_back(r);
    endfunction

    function automatic void add_set(int n, t_value_mix mix, t_order order);
        logic signed [W-1:0] base;
        logic signed [W-1:0] step;
        logic signed [W-1:0] v;
        base = pick_value(mix);
        step = $urandom_range(0, 1000);
        for (int k = 0; k < n; k++) begin
            case (order)
                ORD_RISING:  v = base + k * step;
                ORD_FALLING: v = base - k * step;
                default:     v = pick_value(mix);
            endcase
            push_sample(v, k == n - 1);
        end
    endfunction

    // collect one accepted request; a final item sorts the set and queues results
    function automatic void collect_sample(logic signed [W-1:0] v, logic fin);
        logic signed [W-1:0] arr[DEPTH];
        logic signed [W-1:0] t;
        t_sorted_word        e;
        int                  n;
        int                  lim;
        logic                swapped;
        if (set_vals.size() < DEPTH) begin
            set_vals.push_back(v);
        end else begin
            set_dropped = 1'b1;
        end
        if (!fin) return;
        n = set_vals.size();
        for (int i = 0; i < n; i++) arr[i] = set_vals[i];
        if (n >= 2) begin
            lim = n - 1;
            do begin
                swapped = 1'b0;
                for (int i = 0; i < lim; i++) begin
                    if (arr[i] > arr[i+1]) begin
                        t        = arr[i];
                        arr[i]   = arr[i+1];
                        arr[i+1] = t;
                        swapped  = 1'b1;
                    end
                end
                lim--;
            end while (swapped && lim > 0);
        end
        for (int i = 0; i < n; i++) begin
            e.value = arr[i];
            e.last  = (i == n - 1);
            e.drop  = set_dropped;
            sorted_due.push_back(e);
        end
        sets_sorted++;
        if (set_dropped) overflow_sets++;
        set_vals.delete();
        set_dropped = 1'b0;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_sample_req nxt;
        logic        took;
        took = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (took) collect_sample(i_sample, i_final_item);
            if (!i_valid || took) begin
                if (gap_left == 0 && samples_pending.size() > 0) begin
                    nxt = samples_pending.pop_front();
                    i_valid      <= 1'b1;
                    i_sample     <= nxt.value;
                    i_final_item <= nxt.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // result monitor and output stall pattern
    always @(posedge i_clk) begin
        t_sorted_word e;
        logic         stall_nxt;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                values_seen++;
                if (sorted_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 20)
                        $display("%0t: unexpected result value=%0d end=%0b drop=%0b", $time,
                                 $signed(o_sorted_value), o_end_of_run, o_dropped);
                end else begin
                    e = sorted_due.pop_front();
                    if (o_sorted_value !== e.value) begin
                        mismatches++;
                        if (mismatches <= 20)
                            $display("%0t: sorted_value expected %0d actual %0d", $time,
                                     e.value, $signed(o_sorted_value));
                    end
                    if (o_end_of_run !== e.last) begin
                        mismatches++;
                        if (mismatches <= 20)
                            $display("%0t: end_of_run expected %0b actual %0b", $time,
                                     e.last, o_end_of_run);
                    end
                    if (o_dropped !== e.drop) begin
                        mismatches++;
                        if (mismatches <= 20)
                            $display("%0t: dropped expected %0b actual %0b", $time,
                                     e.drop, o_dropped);
                    end
                end
            end
            if (stall_span == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_span = $urandom_range(32, 256);
            end else begin
                stall_span--;
            end
            stall_tick++;
            case (stall_mode)
                STALL_HALF:  stall_nxt = 1'($urandom_range(0, 1));
                STALL_HEAVY: stall_nxt = ($urandom_range(0, 3) != 0);
                STALL_COMB:  stall_nxt = (stall_tick % 7) < 3;
                default:     stall_nxt = 1'b0;
            endcase
            i_stall <= stall_nxt && !flush;
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                     IDLE_LIMIT, sorted_due.size());
            $display("tb_bubble_sort_ascending: errors");
            $finish;
        end
    end

    initial begin
        int n;
        int r;
        // single element, the most negative value
        push_sample(S_MIN, 1'b1);
        // extremes in mixed order with a duplicate
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b0);
        push_sample('0, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(-1, 1'b1);
        // overfull set, the final request itself dropped
        push_sample(S_MAX, 1'b0);
        for (int k = 1; k < 17; k++) push_sample(1000003 * (8 - k), 1'b0);
        push_sample(S_MIN, 1'b1);

        n = 0;
        while (n < RAND_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                r = $urandom_range(1, DEPTH);
            end else if (r == 7) begin
                r = DEPTH;
            end else begin
                r = $urandom_range(DEPTH + 1, DEPTH + 5);
            end
            add_set(r, t_value_mix'($urandom_range(0, 2)), t_order'($urandom_range(0, 2)));
            n += r;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (samples_pending.size() != 0 || i_valid) @(posedge i_clk);
        while (sorted_due.size() != 0) @(posedge i_clk);
        flush <= 1'b1;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sorted %0d sets, %0d of them overfull; %0d output words checked",
                 sets_sorted, overflow_sets, values_seen);
        if (mismatches == 0) begin
            $display("tb_bubble_sort_ascending: clean");
        end else begin
            $display("tb_bubble_sort_ascending: errors");
        end
        $finish;
    end

endmodule
